// ===== rtl/card_number_luhn_classifier_top_defines.svh =====
// assertion macros for the card number check block
// used by the modules that carry concurrent checks; no other dependencies
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_TOP_DEFINES_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CNLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CNLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cnlc_pkg.sv =====
// shared types, constants and helpers for the card number check block
// no dependencies
`default_nettype none

package cnlc_pkg;

  // word and converter geometry
  localparam int unsigned CARD_W     = 63;
  localparam int unsigned BCD_DIGITS = 19;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned DD_STEPS   = 8;
  localparam int unsigned DD_STAGES  = (CARD_W + DD_STEPS - 1) / DD_STEPS;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned TOTAL_W    = 8;

  // shift-and-add-3 correction
  localparam logic [3:0] DD_ADJ_MIN = 4'd5;
  localparam logic [3:0] DD_ADJ     = 4'd3;

  // accepted lengths
  localparam logic [COUNT_W-1:0] LEN_A = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_B = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_C = 5'd16;

  // prefix digits
  localparam logic [3:0] DIG_THREE = 4'd3;
  localparam logic [3:0] DIG_FOUR  = 4'd4;
  localparam logic [3:0] DIG_FIVE  = 4'd5;
  localparam logic [3:0] DIG_SEVEN = 4'd7;
  localparam logic [3:0] DIG_ONE   = 4'd1;

  // remainder by ten through a reciprocal, exact for values below 1029
  localparam logic [15:0] MOD10_RECIP = 16'd205;
  localparam int unsigned MOD10_SHIFT = 11;

  typedef enum logic [1:0] {
    CLASS_INVALID = 2'd0,
    CLASS_3X      = 2'd1,
    CLASS_5X      = 2'd2,
    CLASS_4X      = 2'd3
  } card_class_e;

  // what the digit stage hands to the classifier
  typedef struct packed {
    logic               too_long;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [3:0]         hi;
    logic [3:0]         lo;
  } digit_info_t;

  typedef struct packed {
    card_class_e        card_class;
    logic               checksum_ok;
    logic [COUNT_W-1:0] digit_count;
  } result_t;

  // sum of the decimal digits of twice a digit
  function automatic logic [3:0] dbl_digit_sum(input logic [3:0] d);
    logic [4:0] p;
    p = {d, 1'b0};
    if (d >= DD_ADJ_MIN) begin
      return 4'(p - 5'd9);
    end
    return p[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cnlc_if.sv =====
// valid/ready channels of the card number check block
// depends on cnlc_pkg
`default_nettype none

interface cnlc_in_if import cnlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card_value;

  modport source (output valid, output card_value, input ready);
  modport sink   (input valid, input card_value, output ready);
endinterface

interface cnlc_out_if import cnlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         card_class;
  logic               checksum_ok;
  logic [COUNT_W-1:0] digit_count;

  modport source (output valid, output card_class, output checksum_ok,
                  output digit_count, input ready);
  modport sink   (input valid, input card_class, input checksum_ok,
                  input digit_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/cnlc_dd_stage.sv =====
// one register stage of the binary to decimal converter (shift and add 3)
// depends on cnlc_pkg
`default_nettype none

module cnlc_dd_stage import cnlc_pkg::*; #(
  parameter int unsigned STEPS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [BCD_W-1:0]  bcd_i,
  input  wire logic [CARD_W-1:0] bin_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [BCD_W-1:0]       bcd_o,
  output logic [CARD_W-1:0]      bin_o
);

  logic              valid_q;
  logic [BCD_W-1:0]  bcd_d, bcd_q;
  logic [CARD_W-1:0] bin_d, bin_q;

  // stage takes a word when empty or when its word moves on
  assign ready_o = !valid_q || ready_i;

  // STEPS iterations of correct-then-shift
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (bcd_d[4*k +: 4] >= DD_ADJ_MIN) begin
          bcd_d[4*k +: 4] = bcd_d[4*k +: 4] + DD_ADJ;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[CARD_W-1]};
      bin_d = {bin_d[CARD_W-2:0], 1'b0};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

`default_nettype wire

// ===== rtl/cnlc_digit_sum.sv =====
// digit stage: length, Luhn total and the two leading digits
// depends on cnlc_pkg
`default_nettype none

module cnlc_digit_sum import cnlc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [BCD_W-1:0] bcd_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output digit_info_t           info_o
);

  localparam int unsigned GROUP  = 4;
  localparam int unsigned GROUPS = (MAX_DIGITS + GROUP - 1) / GROUP;

  logic                 valid_q;
  digit_info_t          info_d, info_q;
  logic [3:0]           dig [BCD_DIGITS];
  logic [3:0]           term [GROUPS*GROUP];
  logic [TOTAL_W-1:0]   part [GROUPS];
  logic [TOTAL_W-1:0]   total;
  logic [COUNT_W-1:0]   cnt;
  logic                 too_long;

  assign ready_o = !valid_q || ready_i;

  // unpack digits
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dig[i] = bcd_i[4*i +: 4];
    end
  end

  // per-digit Luhn terms, doubled on every second digit from the right
  always_comb begin
    for (int i = 0; i < GROUPS*GROUP; i++) begin
      if (i >= MAX_DIGITS) begin
        term[i] = 4'd0;
      end else if ((i % 2) == 1) begin
        term[i] = dbl_digit_sum(dig[i]);
      end else begin
        term[i] = dig[i];
      end
    end
  end

  // two-level adder: groups of four, then the group sums
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        part[g] = part[g] + TOTAL_W'(term[g*GROUP + j]);
      end
    end
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + part[g];
    end
  end

  // digit count and overflow beyond the converter width
  always_comb begin
    cnt      = COUNT_W'(1);
    too_long = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        cnt = COUNT_W'(i + 1);
      end
    end
    for (int i = MAX_DIGITS; i < BCD_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        too_long = 1'b1;
      end
    end
    if (too_long) begin
      cnt = COUNT_W'(MAX_DIGITS);
    end
  end

  // leading digits, only for the accepted lengths
  always_comb begin
    info_d          = '0;
    info_d.too_long = too_long;
    info_d.count    = cnt;
    info_d.total    = total;
    case (cnt)
      LEN_A: begin
        info_d.hi = dig[LEN_A-1];
        info_d.lo = dig[LEN_A-2];
      end
      LEN_B: begin
        info_d.hi = dig[LEN_B-1];
        info_d.lo = dig[LEN_B-2];
      end
      LEN_C: begin
        info_d.hi = dig[LEN_C-1];
        info_d.lo = dig[LEN_C-2];
      end
      default: begin
        info_d.hi = 4'd0;
        info_d.lo = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign info_o  = info_q;

endmodule

`default_nettype wire

// ===== rtl/cnlc_classify.sv =====
// final stage: checksum test, length test and prefix class
// depends on cnlc_pkg and the assertion macro header
`default_nettype none
`include "card_number_luhn_classifier_top_defines.svh"

module cnlc_classify import cnlc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire digit_info_t info_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output result_t          result_o
);

  logic        valid_q;
  result_t     result_d, result_q;
  logic [15:0] prod;
  logic [4:0]  quot;
  logic        sum_ok;
  logic        len_ok;
  card_class_e cls;

  assign ready_o = !valid_q || ready_i;

  // total is a multiple of ten when it equals ten times its quotient
  always_comb begin
    prod   = 16'(info_i.total) * MOD10_RECIP;
    quot   = prod[MOD10_SHIFT +: 5];
    sum_ok = (info_i.total == (8'({quot, 3'b000}) + 8'({quot, 1'b0})));
  end

  // length and prefix
  always_comb begin
    len_ok = !info_i.too_long && (info_i.count inside {LEN_A, LEN_B, LEN_C});
    cls    = CLASS_INVALID;
    if (len_ok && sum_ok) begin
      if (info_i.hi == DIG_THREE && (info_i.lo == DIG_FOUR || info_i.lo == DIG_SEVEN)) begin
        cls = CLASS_3X;
      end else if (info_i.hi == DIG_FIVE && info_i.lo inside {[DIG_ONE:DIG_FIVE]}) begin
        cls = CLASS_5X;
      end else if (info_i.hi == DIG_FOUR) begin
        cls = CLASS_4X;
      end
    end
    result_d.card_class  = cls;
    result_d.checksum_ok = sum_ok;
    result_d.digit_count = info_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // a classed number has passed the checksum
  `CNLC_ASSERT_IMP(a_class_needs_sum, clk_i, rst_ni,
    valid_q && result_q.card_class != CLASS_INVALID, result_q.checksum_ok,
    "class given without checksum")
  // a classed number has an accepted length
  `CNLC_ASSERT_IMP(a_class_needs_len, clk_i, rst_ni,
    valid_q && result_q.card_class != CLASS_INVALID,
    result_q.digit_count == LEN_A || result_q.digit_count == LEN_B ||
    result_q.digit_count == LEN_C,
    "class given for wrong length")
  // count stays within the converter range
  `CNLC_ASSERT_IMP(a_count_range, clk_i, rst_ni, valid_q,
    result_q.digit_count != '0 && result_q.digit_count <= COUNT_W'(MAX_DIGITS),
    "digit count out of range")
  // a held result keeps its word
  `CNLC_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_q && !ready_i,
    valid_q && $stable(result_q), "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/card_number_luhn_classifier_top.sv =====
// Card number check: binary to decimal conversion, Luhn mod-10 test, prefix class.
//
// Input channel in_i carries one 63-bit card number per word; output channel
// out_o carries the class (0 invalid, 1 leading 34/37, 2 leading 51..55,
// 3 leading 4), the checksum flag and the decimal digit count.
// An input word passes through eight converter stages (eight shift-and-add-3
// steps each, seven in the last), one digit stage (length, Luhn total, leading
// digits) and one output stage before it leaves as its output word.
// Throughput is one word per cycle without stalls; every stage holds a valid
// bit and takes a new word whenever it is empty or its word moves on.
// When the receiver stalls, ready falls back stage by stage; each stage holds
// its word, so nothing is lost or repeated, and in_i.ready drops only once
// the whole pipeline is full.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// depends on cnlc_pkg, cnlc_if and the stage modules
`default_nettype none

module card_number_luhn_classifier_top import cnlc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cnlc_in_if.sink    in_i,
  cnlc_out_if.source out_o
);

  logic              dd_valid [DD_STAGES+1];
  logic              dd_ready [DD_STAGES+1];
  logic [BCD_W-1:0]  dd_bcd   [DD_STAGES+1];
  logic [CARD_W-1:0] dd_bin   [DD_STAGES+1];

  logic        ds_valid, ds_ready;
  digit_info_t ds_info;
  result_t     result;

  // converter input
  assign dd_valid[0] = in_i.valid;
  assign in_i.ready  = dd_ready[0];
  assign dd_bcd[0]   = '0;
  assign dd_bin[0]   = in_i.card_value;

  // converter pipeline
  for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
    localparam int unsigned LEFT  = CARD_W - s * DD_STEPS;
    localparam int unsigned STEPS = (LEFT > DD_STEPS) ? DD_STEPS : LEFT;
    cnlc_dd_stage #(
      .STEPS(STEPS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dd_valid[s]),
      .ready_o(dd_ready[s]),
      .bcd_i  (dd_bcd[s]),
      .bin_i  (dd_bin[s]),
      .valid_o(dd_valid[s+1]),
      .ready_i(dd_ready[s+1]),
      .bcd_o  (dd_bcd[s+1]),
      .bin_o  (dd_bin[s+1])
    );
  end

  // digit stage
  cnlc_digit_sum #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(dd_valid[DD_STAGES]),
    .ready_o(dd_ready[DD_STAGES]),
    .bcd_i  (dd_bcd[DD_STAGES]),
    .valid_o(ds_valid),
    .ready_i(ds_ready),
    .info_o (ds_info)
  );

  // output stage
  cnlc_classify #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ds_valid),
    .ready_o (ds_ready),
    .info_i  (ds_info),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .result_o(result)
  );

  assign out_o.card_class  = result.card_class;
  assign out_o.checksum_ok = result.checksum_ok;
  assign out_o.digit_count = result.digit_count;

endmodule

`default_nettype wire
